### rtl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("port assertion failed");

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("reset assertion failed");

`endif

### rtl/rgbyv_pkg.sv
// shared constants and types of the rgb to yv12 encoder
package rgbyv_pkg;

    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_STRIDE_ALIGN = 16;

    localparam int ADDR_W    = 25;
    localparam int DIM_W     = 14;
    localparam int REG_W     = 13;
    localparam int CFG_IDX_W = 4;
    localparam int PIX_W     = 24;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_V = 2'd1;
    localparam logic [1:0] PLANE_U = 2'd2;

    typedef struct packed {
        logic              ready;
        logic              load;
        logic [DIM_W-1:0]  eff_w;
        logic [DIM_W-1:0]  eff_h;
        logic [DIM_W-1:0]  row_step;
        logic [ADDR_W-1:0] first_base;
        logic [ADDR_W-1:0] second_base;
    } geom_t;

    typedef struct packed {
        logic              chroma;
        logic [7:0]        y;
        logic [7:0]        u;
        logic [7:0]        v;
        logic [ADDR_W-1:0] luma_addr;
        logic [ADDR_W-1:0] v_addr;
        logic [ADDR_W-1:0] u_addr;
    } px_cmd_t;

endpackage

### rtl/rgbyv_fifo.sv
// short command queue between the pixel front end and the byte sequencer
module rgbyv_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rgbyv_pkg::px_cmd_t wr_data,
    output logic               full,
    input  logic               pop,
    output rgbyv_pkg::px_cmd_t rd_data,
    output logic               nonempty
);
    import rgbyv_pkg::*;

    px_cmd_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/rgbyv_geom.sv
// frame size registers and the sequencer that derives plane geometry from them
module rgbyv_geom #(
    parameter int MAX_WIDTH    = rgbyv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = rgbyv_pkg::DEF_MAX_HEIGHT,
    parameter int STRIDE_ALIGN = rgbyv_pkg::DEF_STRIDE_ALIGN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr,
    input  logic [rgbyv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbyv_pkg::REG_W-1:0]      cfg_data,
    output rgbyv_pkg::geom_t                 geom
);
    import rgbyv_pkg::*;

    localparam int DIV_W  = $clog2(MAX_WIDTH + 2 * STRIDE_ALIGN);
    localparam int RSH    = DIV_W + $clog2(STRIDE_ALIGN);
    localparam int RECIP  = ((1 << RSH) + STRIDE_ALIGN - 1) / STRIDE_ALIGN;
    localparam int RP_W   = 2 * DIV_W + 1;
    localparam int PROD_W = DIV_W + DIM_W;
    localparam int FS_W   = 2 * DIM_W;
    localparam int SUM_W  = 2 * DIM_W + 1;

    typedef enum logic [2:0] {
        G_CLAMP, G_DIV_L, G_LOAD_C, G_DIV_C, G_STRIDE, G_MUL, G_FIN, G_DONE
    } gstate_t;

    gstate_t             state_reg;
    logic [REG_W-1:0]    width_reg;
    logic [REG_W-1:0]    height_reg;
    logic [DIM_W-1:0]    eff_w_reg;
    logic [DIM_W-1:0]    eff_h_reg;
    logic [DIV_W-1:0]    num_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    chroma_stride_reg;
    logic [FS_W-1:0]     fsize_reg;
    logic [PROD_W-1:0]   cprod_reg;
    logic [DIM_W-1:0]    row_step_reg;
    logic [ADDR_W-1:0]   first_base_reg;
    logic [ADDR_W-1:0]   second_base_reg;
    logic                ready_reg;
    logic                load_reg;

    logic [DIM_W-1:0]    eff_w_c;
    logic [DIM_W-1:0]    eff_h_c;
    logic [RP_W-1:0]     recip_prod;
    logic [DIV_W-1:0]    quo_c;
    logic [DIV_W-1:0]    aligned;
    logic                size_write;

    // zero counts as one, anything above the maximum is held at the maximum
    always_comb begin
        if (width_reg == '0) begin
            eff_w_c = DIM_W'(1);
        end else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) begin
            eff_w_c = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w_c = DIM_W'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h_c = DIM_W'(1);
        end else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) begin
            eff_h_c = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h_c = DIM_W'(height_reg);
        end
    end

    // divide by the alignment with a reciprocal multiply, exact for any DIV_W-bit numerator
    assign recip_prod = RP_W'(num_reg) * RP_W'(RECIP);
    assign quo_c      = DIV_W'(recip_prod >> RSH);
    assign aligned    = quo_reg * DIV_W'(STRIDE_ALIGN);

    assign size_write = cfg_wr &&
                        (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= REG_W'(640);
            height_reg <= REG_W'(480);
            state_reg  <= G_CLAMP;
            ready_reg  <= 1'b0;
            load_reg   <= 1'b0;
        end else begin
            load_reg <= 1'b0;
            if (size_write) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    width_reg <= cfg_data;
                end else begin
                    height_reg <= cfg_data;
                end
                state_reg <= G_CLAMP;
                ready_reg <= 1'b0;
            end else begin
                unique case (state_reg)
                    G_CLAMP: begin
                        eff_w_reg <= eff_w_c;
                        eff_h_reg <= eff_h_c;
                        num_reg   <= DIV_W'(eff_w_c) + DIV_W'(STRIDE_ALIGN - 1);
                        state_reg <= G_DIV_L;
                    end
                    G_DIV_L: begin
                        quo_reg   <= quo_c;
                        state_reg <= G_LOAD_C;
                    end
                    G_LOAD_C: begin
                        // luma stride halved, then rounded up again
                        num_reg   <= (aligned >> 1) + DIV_W'(STRIDE_ALIGN - 1);
                        state_reg <= G_DIV_C;
                    end
                    G_DIV_C: begin
                        quo_reg   <= quo_c;
                        state_reg <= G_STRIDE;
                    end
                    G_STRIDE: begin
                        chroma_stride_reg <= aligned;
                        state_reg         <= G_MUL;
                    end
                    G_MUL: begin
                        fsize_reg <= FS_W'(eff_w_reg) * FS_W'(eff_h_reg);
                        cprod_reg <= PROD_W'(chroma_stride_reg) * PROD_W'(eff_h_reg);
                        state_reg <= G_FIN;
                    end
                    G_FIN: begin
                        row_step_reg    <= DIM_W'((chroma_stride_reg -
                                                   DIV_W'(eff_w_reg >> 1)) >> 1);
                        first_base_reg  <= ADDR_W'(fsize_reg);
                        second_base_reg <= ADDR_W'(SUM_W'(fsize_reg) +
                                                   SUM_W'(cprod_reg >> 1));
                        load_reg        <= 1'b1;
                        state_reg       <= G_DONE;
                    end
                    G_DONE: begin
                        // pixels only once the front end has taken the new bases
                        ready_reg <= 1'b1;
                        state_reg <= G_DONE;
                    end
                    default: begin
                        state_reg <= G_CLAMP;
                    end
                endcase
            end
        end
    end

    assign geom.ready       = ready_reg;
    assign geom.load        = load_reg;
    assign geom.eff_w       = eff_w_reg;
    assign geom.eff_h       = eff_h_reg;
    assign geom.row_step    = row_step_reg;
    assign geom.first_base  = first_base_reg;
    assign geom.second_base = second_base_reg;

endmodule

### rtl/rgbyv_front.sv
// pixel intake: colour conversion, raster counters and plane addresses
module rgbyv_front #(
    parameter int MAX_WIDTH  = rgbyv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbyv_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rgbyv_pkg::geom_t             geom,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rgbyv_pkg::PIX_W-1:0]  s_rgb_pixel,
    input  logic                         q_full,
    output logic                         q_push,
    output rgbyv_pkg::px_cmd_t           q_data
);
    import rgbyv_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               parity_reg;
    logic [ADDR_W-1:0]  luma_reg;
    logic [ADDR_W-1:0]  first_reg;
    logic [ADDR_W-1:0]  second_reg;

    logic               accept;
    logic               chroma;
    logic               col_end;
    logic               row_end;
    logic [ADDR_W-1:0]  first_inc;
    logic [ADDR_W-1:0]  second_inc;
    logic signed [17:0] r_s;
    logic signed [17:0] g_s;
    logic signed [17:0] b_s;
    logic signed [17:0] sum_y;
    logic signed [17:0] sum_u;
    logic signed [17:0] sum_v;

    function automatic logic [7:0] clamp_byte(input logic signed [17:0] v);
        if (v < 18'sd0) begin
            return 8'd0;
        end else if (v > 18'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    assign s_ready = geom.ready && !q_full;
    assign accept  = s_valid && s_ready;

    assign r_s = $signed({10'd0, s_rgb_pixel[23:16]});
    assign g_s = $signed({10'd0, s_rgb_pixel[15:8]});
    assign b_s = $signed({10'd0, s_rgb_pixel[7:0]});

    // bt.601 integer weights, rounded and floored by eight bits
    assign sum_y = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
    assign sum_u = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
    assign sum_v = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;

    assign chroma     = !row_reg[0] && !parity_reg;
    assign col_end    = (DIM_W'(col_reg) + 1'b1) >= geom.eff_w;
    assign row_end    = (DIM_W'(row_reg) + 1'b1) >= geom.eff_h;
    assign first_inc  = first_reg + ADDR_W'(chroma);
    assign second_inc = second_reg + ADDR_W'(chroma);

    assign q_push           = accept;
    assign q_data.chroma    = chroma;
    assign q_data.y         = clamp_byte((sum_y >>> 8) + 18'sd16);
    assign q_data.u         = clamp_byte((sum_u >>> 8) + 18'sd128);
    assign q_data.v         = clamp_byte((sum_v >>> 8) + 18'sd128);
    assign q_data.luma_addr = luma_reg;
    assign q_data.v_addr    = first_reg;
    assign q_data.u_addr    = second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            parity_reg <= 1'b0;
            luma_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end else if (geom.load || (accept && col_end && row_end)) begin
            // new geometry or end of frame
            col_reg    <= '0;
            row_reg    <= '0;
            parity_reg <= 1'b0;
            luma_reg   <= '0;
            first_reg  <= geom.first_base;
            second_reg <= geom.second_base;
        end else if (accept) begin
            luma_reg   <= luma_reg + 1'b1;
            parity_reg <= !parity_reg;
            if (col_end) begin
                col_reg    <= '0;
                row_reg    <= row_reg + 1'b1;
                first_reg  <= first_inc + ADDR_W'(geom.row_step);
                second_reg <= second_inc + ADDR_W'(geom.row_step);
            end else begin
                col_reg    <= col_reg + 1'b1;
                first_reg  <= first_inc;
                second_reg <= second_inc;
            end
        end
    end

endmodule

### rtl/rgbyv_back.sv
// byte sequencer: one queued pixel becomes one or three byte writes
module rgbyv_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_nonempty,
    input  rgbyv_pkg::px_cmd_t            q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgbyv_pkg::ADDR_W-1:0]  m_byte_address,
    output logic [7:0]                    m_byte_value,
    output logic [1:0]                    m_plane,
    output logic                          m_last_of_pixel
);
    import rgbyv_pkg::*;

    typedef enum logic [1:0] {PH_Y, PH_V, PH_U} phase_t;

    phase_t             phase_reg;
    logic               m_valid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [7:0]         value_reg;
    logic [1:0]         plane_reg;
    logic               last_reg;
    logic               load;

    assign load  = q_nonempty && (!m_valid_reg || m_ready);
    assign q_pop = load && ((phase_reg == PH_Y && !q_head.chroma) || phase_reg == PH_U);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_Y;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load) begin
                unique case (phase_reg)
                    PH_Y: begin
                        addr_reg  <= q_head.luma_addr;
                        value_reg <= q_head.y;
                        plane_reg <= PLANE_Y;
                        last_reg  <= !q_head.chroma;
                        phase_reg <= q_head.chroma ? PH_V : PH_Y;
                    end
                    PH_V: begin
                        addr_reg  <= q_head.v_addr;
                        value_reg <= q_head.v;
                        plane_reg <= PLANE_V;
                        last_reg  <= 1'b0;
                        phase_reg <= PH_U;
                    end
                    PH_U: begin
                        addr_reg  <= q_head.u_addr;
                        value_reg <= q_head.u;
                        plane_reg <= PLANE_U;
                        last_reg  <= 1'b1;
                        phase_reg <= PH_Y;
                    end
                    default: begin
                        phase_reg <= PH_Y;
                    end
                endcase
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_byte_address  = addr_reg;
    assign m_byte_value    = value_reg;
    assign m_plane         = plane_reg;
    assign m_last_of_pixel = last_reg;

endmodule

### rtl/rgb_to_yv12_planar_encoder.sv
// top level of the rgb888 to yv12 planar encoder
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (frame width/height)
//  s       | in        | s_valid/s_ready    | s_rgb_pixel
//  m       | out       | m_valid/m_ready    | m_byte_address, m_byte_value, m_plane,
//          |           |                    | m_last_of_pixel
//
// one byte request leaves per cycle from the output register while m_ready is high and
// a pixel is queued; a luma-only pixel gives one request, a pixel with chroma three;
// every other pixel carries chroma along even rows, none on odd rows; the front end takes
// a pixel per cycle into a four-entry queue while that queue has room and geometry is
// ready; after reset and each size write s_ready stays low while strides and plane bases
// are worked out; reset is synchronous and active low; cfg_ready stays high
module rgb_to_yv12_planar_encoder #(
    parameter int MAX_WIDTH    = rgbyv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = rgbyv_pkg::DEF_MAX_HEIGHT,
    parameter int STRIDE_ALIGN = rgbyv_pkg::DEF_STRIDE_ALIGN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rgbyv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbyv_pkg::REG_W-1:0]      cfg_data,
    // pixel requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rgbyv_pkg::PIX_W-1:0]      s_rgb_pixel,
    // byte write requests
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rgbyv_pkg::ADDR_W-1:0]     m_byte_address,
    output logic [7:0]                       m_byte_value,
    output logic [1:0]                       m_plane,
    output logic                             m_last_of_pixel
);
    import rgbyv_pkg::*;

    geom_t    geom;
    px_cmd_t  push_data;
    px_cmd_t  head_data;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_nonempty;
    logic     cfg_wr;

    // writes are always taken; a size write restarts the frame
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // frame geometry: strides, plane bases and the per-row chroma step
    rgbyv_geom #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .STRIDE_ALIGN (STRIDE_ALIGN)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // front end: converts the pixel and works out where its bytes land
    rgbyv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .geom        (geom),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rgb_pixel (s_rgb_pixel),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    // decouples pixel intake from byte output
    rgbyv_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (push_data),
        .full     (q_full),
        .pop      (q_pop),
        .rd_data  (head_data),
        .nonempty (q_nonempty)
    );

    // back end: luma, then v and u on chroma pixels
    rgbyv_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_nonempty      (q_nonempty),
        .q_head          (head_data),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_address  (m_byte_address),
        .m_byte_value    (m_byte_value),
        .m_plane         (m_plane),
        .m_last_of_pixel (m_last_of_pixel)
    );

endmodule

### rtl/rgbyv_checker.sv
// port-level checks of the encoder, bound to the top level
`include "assert_macros.svh"

module rgbyv_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [rgbyv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [rgbyv_pkg::ADDR_W-1:0]     m_byte_address,
    input logic [7:0]                       m_byte_value,
    input logic [1:0]                       m_plane,
    input logic                             m_last_of_pixel
);
    import rgbyv_pkg::*;

    // a stalled byte request holds its payload
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_byte_address) && $stable(m_byte_value) && $stable(m_plane))

    // a u byte always closes its pixel
    `ASSERT_CLK(a_u_last, aclk, aresetn, m_valid && m_plane == PLANE_U |-> m_last_of_pixel)

    // a size write closes the pixel channel while geometry is rebuilt
    `ASSERT_CLK(a_cfg_block, aclk, aresetn, cfg_valid && cfg_ready && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) |=> !s_ready)

    // nothing is offered straight after reset
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid && !s_ready)

endmodule

bind rgb_to_yv12_planar_encoder rgbyv_checker u_checker (.*);
